// File: src/vmu_pkg.sv
// Shared types, constants and saturation helpers for the vector math unit.
package vmu_pkg;

  localparam int VEC_LEN  = 3;
  localparam int MAXE     = 4;
  localparam int FRAC     = 16;
  localparam int SQRT_STG = 32;
  localparam int DIV_STG  = FRAC + 1;
  localparam int SQ_STG   = 2;
  localparam int FAST_STG = SQ_STG + MAXE;
  localparam int UNIT_STG = SQ_STG + SQRT_STG + DIV_STG;
  localparam int PIPE_LAT = UNIT_STG + 1;
  localparam int FAST_DLY = UNIT_STG - FAST_STG;

  localparam logic signed [63:0] ACC_LIM = 64'sh2000_0000_0000_0000;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_SCALE = 3'd2,
    CMD_DOT   = 3'd3,
    CMD_MAG   = 3'd4,
    CMD_CROSS = 3'd5,
    CMD_UNIT  = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [MAXE-1:0][31:0] r;
    logic [31:0]           scal;
    logic                  sat;
  } res_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [MAXE-1:0][31:0] a;
  } tag_t;

  function automatic sat_t sat32(input logic signed [64:0] v);
    sat_t o;
    if (v > 65'sd2147483647) begin
      o.val = 32'h7FFF_FFFF;
      o.sat = 1'b1;
    end else if (v < -65'sd2147483648) begin
      o.val = 32'h8000_0000;
      o.sat = 1'b1;
    end else begin
      o.val = v[31:0];
      o.sat = 1'b0;
    end
    return o;
  endfunction

  function automatic logic signed [63:0] dclamp(input logic signed [63:0] v);
    logic signed [63:0] o;
    if (v > ACC_LIM) begin
      o = ACC_LIM;
    end else if (v < -ACC_LIM) begin
      o = -ACC_LIM;
    end else begin
      o = v;
    end
    return o;
  endfunction

endpackage

// File: src/vmu_lane.sv
// One element lane: add, subtract, scale and the element products.
module vmu_lane import vmu_pkg::*; (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] s_i,
  input  cmd_t               cmd_s1,
  output logic [63:0]        pab_o,
  output logic [63:0]        paa_o,
  output sat_t               res_o
);

  logic signed [32:0] sum_r;
  logic signed [32:0] dif_r;
  logic signed [63:0] pas_r;
  logic signed [63:0] pab_r;
  logic signed [63:0] paa_r;
  sat_t               res_r;
  sat_t               res_nxt;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= 33'(a_i) + 33'(b_i);
      dif_r <= 33'(a_i) - 33'(b_i);
      pas_r <= 64'(a_i) * 64'(s_i);
      pab_r <= 64'(a_i) * 64'(b_i);
      paa_r <= 64'(a_i) * 64'(a_i);
      res_r <= res_nxt;
    end
  end

  always_comb begin
    case (cmd_s1)
      CMD_ADD:   res_nxt = sat32(65'(sum_r));
      CMD_SUB:   res_nxt = sat32(65'(dif_r));
      CMD_SCALE: res_nxt = sat32(65'(pas_r >>> FRAC));
      default:   res_nxt = '0;
    endcase
  end

  assign pab_o = pab_r;
  assign paa_o = paa_r;
  assign res_o = res_r;

endmodule

// File: src/vmu_merge.sv
// Merge stage: dot product chain, sum of squares, cross product and result assembly.
module vmu_merge import vmu_pkg::*; (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [MAXE-1:0][31:0] a_v,
  input  logic [MAXE-1:0][31:0] b_v,
  input  logic [MAXE-1:0][63:0] pab_v,
  input  logic [MAXE-1:0][63:0] paa_v,
  input  sat_t [MAXE-1:0]       lres_v,
  input  cmd_t                  cmd_s2,
  output logic [63:0]           sqsum_o,
  output res_t                  fast_o
);

  logic signed [63:0]    cp_r [3];
  logic signed [63:0]    cn_r [3];
  logic signed [64:0]    cd_r [3];
  sat_t [MAXE-1:0]       xr;
  logic [65:0]           sq_nxt;
  logic [63:0]           sqsum_r;
  logic signed [63:0]    acc_r [MAXE];
  logic [MAXE-1:0][63:0] pd_r [MAXE];
  res_t                  res3_nxt;
  res_t                  rp_r [MAXE-1];
  res_t                  fast_nxt;
  res_t                  fast_r;
  sat_t                  dsat;

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int P = (i + 1) % 3;
    localparam int N = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        cp_r[i] <= 64'($signed(a_v[P])) * 64'($signed(b_v[N]));
        cn_r[i] <= 64'($signed(a_v[N])) * 64'($signed(b_v[P]));
        cd_r[i] <= 65'(cp_r[i]) - 65'(cn_r[i]);
      end
    end
  end

  for (genvar i = 0; i < MAXE; i++) begin : g_xr
    if (i < 3 && i < VEC_LEN) begin : g_on
      assign xr[i] = sat32(cd_r[i] >>> FRAC);
    end else begin : g_off
      assign xr[i] = '0;
    end
  end

  always_comb begin
    sq_nxt = '0;
    for (int k = 0; k < MAXE; k++) begin
      sq_nxt = sq_nxt + 66'(paa_v[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqsum_r <= (|sq_nxt[65:64]) ? '1 : sq_nxt[63:0];
    end
  end

  for (genvar k = 0; k < MAXE; k++) begin : g_dot
    always_ff @(posedge clk) begin
      if (adv) begin
        if (k == 0) begin
          acc_r[k] <= dclamp($signed(pab_v[0]));
          pd_r[k]  <= pab_v;
        end else begin
          acc_r[k] <= dclamp(acc_r[k-1] + $signed(pd_r[k-1][k]));
          pd_r[k]  <= pd_r[k-1];
        end
      end
    end
  end

  always_comb begin
    res3_nxt      = '0;
    res3_nxt.cmd  = cmd_s2;
    for (int i = 0; i < MAXE; i++) begin
      if (cmd_s2 == CMD_CROSS) begin
        res3_nxt.r[i] = xr[i].val;
        res3_nxt.sat  = res3_nxt.sat | xr[i].sat;
      end else begin
        res3_nxt.r[i] = lres_v[i].val;
        res3_nxt.sat  = res3_nxt.sat | lres_v[i].sat;
      end
    end
  end

  for (genvar k = 0; k < MAXE - 1; k++) begin : g_res
    always_ff @(posedge clk) begin
      if (adv) begin
        if (k == 0) begin
          rp_r[k] <= res3_nxt;
        end else begin
          rp_r[k] <= rp_r[k-1];
        end
      end
    end
  end

  always_comb begin
    dsat     = sat32(65'(acc_r[MAXE-1] >>> FRAC));
    fast_nxt = rp_r[MAXE-2];
    if (rp_r[MAXE-2].cmd == CMD_DOT) begin
      fast_nxt.scal = dsat.val;
      fast_nxt.sat  = dsat.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fast_r <= fast_nxt;
    end
  end

  assign sqsum_o = sqsum_r;
  assign fast_o  = fast_r;

endmodule

// File: src/vmu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module vmu_sqrt import vmu_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] x_i,
  input  tag_t        tag_i,
  output logic [31:0] root_o,
  output tag_t        tag_o
);

  logic [63:0] x_r    [SQRT_STG];
  logic [32:0] rem_r  [SQRT_STG];
  logic [31:0] root_r [SQRT_STG];
  tag_t        tag_r  [SQRT_STG];

  for (genvar j = 0; j < SQRT_STG; j++) begin : g_stg
    logic [63:0] xp;
    logic [32:0] rp;
    logic [31:0] qp;
    tag_t        tp;
    logic [34:0] rsh;
    logic [34:0] trial;

    if (j == 0) begin : g_first
      assign xp = x_i;
      assign rp = '0;
      assign qp = '0;
      assign tp = tag_i;
    end else begin : g_next
      assign xp = x_r[j-1];
      assign rp = rem_r[j-1];
      assign qp = root_r[j-1];
      assign tp = tag_r[j-1];
    end

    assign rsh   = {rp, xp[63:62]};
    assign trial = {1'b0, qp, 2'b01};

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[j]   <= {xp[61:0], 2'b00};
        tag_r[j] <= tp;
        if (rsh >= trial) begin
          rem_r[j]  <= 33'(rsh - trial);
          root_r[j] <= {qp[30:0], 1'b1};
        end else begin
          rem_r[j]  <= rsh[32:0];
          root_r[j] <= {qp[30:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_r[SQRT_STG-1];
  assign tag_o  = tag_r[SQRT_STG-1];

endmodule

// File: src/vmu_div.sv
// Pipelined restoring divider for one unit-vector element.
module vmu_div import vmu_pkg::*; (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] a_i,
  input  logic [31:0]        m_i,
  output logic signed [31:0] r_o,
  output logic [31:0]        m_o
);

  logic [31+FRAC:0]  rem_r [DIV_STG];
  logic [DIV_STG-1:0] q_r  [DIV_STG];
  logic [31:0]        m_r  [DIV_STG];
  logic               neg_r [DIV_STG];
  logic [31:0]        mag;

  assign mag = a_i[31] ? (~a_i + 32'd1) : a_i;

  for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
    localparam int SH = DIV_STG - 1 - j;
    logic [31+FRAC:0]   rp;
    logic [DIV_STG-1:0] qp;
    logic [31:0]        mp;
    logic               np;
    logic [31+FRAC:0]   cmpv;

    if (j == 0) begin : g_first
      assign rp = {mag, {FRAC{1'b0}}};
      assign qp = '0;
      assign mp = m_i;
      assign np = a_i[31];
    end else begin : g_next
      assign rp = rem_r[j-1];
      assign qp = q_r[j-1];
      assign mp = m_r[j-1];
      assign np = neg_r[j-1];
    end

    assign cmpv = (32+FRAC)'(mp) << SH;

    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[j]   <= mp;
        neg_r[j] <= np;
        if (rp >= cmpv) begin
          rem_r[j] <= rp - cmpv;
          q_r[j]   <= qp | (DIV_STG'(1) << SH);
        end else begin
          rem_r[j] <= rp;
          q_r[j]   <= qp;
        end
      end
    end
  end

  assign r_o = neg_r[DIV_STG-1] ? -32'(q_r[DIV_STG-1]) : 32'(q_r[DIV_STG-1]);
  assign m_o = m_r[DIV_STG-1];

endmodule

// File: src/vector_math_unit.sv
// Vector math unit: element-wise add, subtract, scale, dot, magnitude, cross and unit vector on
// Q16.16 vectors. The unit is a single pipeline that accepts one transaction every cycle while it
// is not stalled and returns each result in order. Magnitude and unit-vector results pass the
// 32-stage square root and then the 17-stage divider; the other results wait in a delay line matched
// to that path. While a finished result waits on out_ready the whole pipeline holds and in_ready is low.
module vector_math_unit import vmu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_a_0,
  input  logic signed [31:0] in_a_1,
  input  logic signed [31:0] in_a_2,
  input  logic signed [31:0] in_a_3,
  input  logic signed [31:0] in_b_0,
  input  logic signed [31:0] in_b_1,
  input  logic signed [31:0] in_b_2,
  input  logic signed [31:0] in_b_3,
  input  logic signed [31:0] in_scale_factor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_r_0,
  output logic signed [31:0] out_r_1,
  output logic signed [31:0] out_r_2,
  output logic signed [31:0] out_r_3,
  output logic signed [31:0] out_scalar_out,
  output logic               out_zero_length,
  output logic               out_saturated
);

  logic                  adv;
  logic [PIPE_LAT-1:0]   vld_r;
  logic [MAXE-1:0][31:0] a_raw;
  logic [MAXE-1:0][31:0] b_raw;
  logic [MAXE-1:0][31:0] a_m;
  logic [MAXE-1:0][31:0] b_m;
  cmd_t                  cmd1_r;
  cmd_t                  cmd2_r;
  logic [MAXE-1:0][31:0] a1_r;
  logic [MAXE-1:0][31:0] a2_r;
  logic [MAXE-1:0][63:0] pab;
  logic [MAXE-1:0][63:0] paa;
  sat_t [MAXE-1:0]       lres;
  logic [63:0]           sqsum;
  res_t                  fast;
  tag_t                  tag_in;
  tag_t                  tag_sq;
  logic [31:0]           root;
  logic [MAXE-1:0][31:0] q;
  logic [MAXE-1:0][31:0] md;
  res_t                  fd_r [FAST_DLY];
  res_t                  fin;
  res_t                  out_nxt;
  logic                  zl_nxt;
  res_t                  out_r;
  logic                  zl_r;

  assign out_valid = vld_r[PIPE_LAT-1];
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  assign a_raw = {in_a_3, in_a_2, in_a_1, in_a_0};
  assign b_raw = {in_b_3, in_b_2, in_b_1, in_b_0};

  for (genvar i = 0; i < MAXE; i++) begin : g_mask
    if (i < VEC_LEN) begin : g_on
      assign a_m[i] = a_raw[i];
      assign b_m[i] = b_raw[i];
    end else begin : g_off
      assign a_m[i] = '0;
      assign b_m[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r <= cmd_t'(in_cmd);
      cmd2_r <= cmd1_r;
      a1_r   <= a_m;
      a2_r   <= a1_r;
    end
  end

  for (genvar i = 0; i < MAXE; i++) begin : g_lane
    vmu_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .a_i    ($signed(a_m[i])),
      .b_i    ($signed(b_m[i])),
      .s_i    (in_scale_factor),
      .cmd_s1 (cmd1_r),
      .pab_o  (pab[i]),
      .paa_o  (paa[i]),
      .res_o  (lres[i])
    );
  end

  vmu_merge u_merge (
    .clk     (clk),
    .adv     (adv),
    .a_v     (a_m),
    .b_v     (b_m),
    .pab_v   (pab),
    .paa_v   (paa),
    .lres_v  (lres),
    .cmd_s2  (cmd2_r),
    .sqsum_o (sqsum),
    .fast_o  (fast)
  );

  assign tag_in.cmd = cmd2_r;
  assign tag_in.a   = a2_r;

  vmu_sqrt u_sqrt (
    .clk    (clk),
    .adv    (adv),
    .x_i    (sqsum),
    .tag_i  (tag_in),
    .root_o (root),
    .tag_o  (tag_sq)
  );

  for (genvar i = 0; i < MAXE; i++) begin : g_div
    vmu_div u_div (
      .clk (clk),
      .adv (adv),
      .a_i ($signed(tag_sq.a[i])),
      .m_i (root),
      .r_o (q[i]),
      .m_o (md[i])
    );
  end

  for (genvar k = 0; k < FAST_DLY; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        if (k == 0) begin
          fd_r[k] <= fast;
        end else begin
          fd_r[k] <= fd_r[k-1];
        end
      end
    end
  end

  assign fin = fd_r[FAST_DLY-1];

  always_comb begin
    out_nxt = fin;
    zl_nxt  = 1'b0;
    case (fin.cmd)
      CMD_MAG: begin
        if (md[0][31]) begin
          out_nxt.scal = 32'h7FFF_FFFF;
          out_nxt.sat  = 1'b1;
        end else begin
          out_nxt.scal = md[0];
        end
      end
      CMD_UNIT: begin
        if (md[0] == '0) begin
          zl_nxt = 1'b1;
        end else begin
          out_nxt.r = q;
        end
      end
      default: begin
        out_nxt = fin;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
      zl_r  <= zl_nxt;
    end
  end

  assign out_r_0         = $signed(out_r.r[0]);
  assign out_r_1         = $signed(out_r.r[1]);
  assign out_r_2         = $signed(out_r.r[2]);
  assign out_r_3         = $signed(out_r.r[3]);
  assign out_scalar_out  = $signed(out_r.scal);
  assign out_zero_length = zl_r;
  assign out_saturated   = out_r.sat;

endmodule

// File: src/vmu_chk.sv
// Port checker for the vector math unit and its bind.
module vmu_chk import vmu_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         in_cmd,
  input logic signed [31:0] in_a_0,
  input logic signed [31:0] in_a_1,
  input logic signed [31:0] in_a_2,
  input logic signed [31:0] in_a_3,
  input logic signed [31:0] in_b_0,
  input logic signed [31:0] in_b_1,
  input logic signed [31:0] in_b_2,
  input logic signed [31:0] in_b_3,
  input logic signed [31:0] in_scale_factor,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_r_0,
  input logic signed [31:0] out_r_1,
  input logic signed [31:0] out_r_2,
  input logic signed [31:0] out_r_3,
  input logic signed [31:0] out_scalar_out,
  input logic               out_zero_length,
  input logic               out_saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_r_0) && $stable(out_scalar_out))
    else $error("result transaction changed while stalled");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> !out_saturated && out_r_0 == 0 && out_r_1 == 0 &&
      out_r_2 == 0 && out_r_3 == 0 && out_scalar_out == 0)
    else $error("zero-length result carries data");

  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (VEC_LEN > 3) || out_r_3 == 0)
    else $error("element beyond vector length is nonzero");

endmodule

bind vector_math_unit vmu_chk u_vmu_chk (.*);
